/* hw/rtl/gwbr_pkg.sv */
package gwbr_pkg;

   // Geometry of the screen and the warp grid.
   localparam int MAX_SCREEN_DIM = 2048;
   localparam int CELL_SHIFT     = 4;

   // Fixed field widths of the two transaction directions.
   localparam int FRACTION_BITS = 16;
   localparam int NODE_W        = FRACTION_BITS + 1;
   localparam int PT_W          = 11;
   localparam int GIDX_W        = 8;
   localparam int OUT_W         = 11;
   localparam int CSR_W         = 12;
   localparam int CSR_IDX_W     = 2;
   localparam int ENTRY_W       = 2 * NODE_W;

   // Opcodes of an input transaction.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_SIZE = 2'd2;

   localparam logic [CSR_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
   localparam logic [CSR_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
   localparam logic [CSR_W-1:0] RST_VIEWPORT_SIZE = 12'd768;

   // Number of clock edges from the accepting edge to the edge that takes the result.
   localparam int MAP_LATENCY = 7;

   typedef struct packed {
      logic              opcode;
      logic [GIDX_W-1:0] grid_col;
      logic [GIDX_W-1:0] grid_row;
      logic [NODE_W-1:0] node_u;
      logic [NODE_W-1:0] node_v;
      logic [PT_W-1:0]   point_x;
      logic [PT_W-1:0]   point_y;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] mapped_x;
      logic [OUT_W-1:0] mapped_y;
   } rsp_type;

endpackage

/* hw/rtl/gwbr_grid_mem.sv */
module gwbr_grid_mem
   import gwbr_pkg::*;
#(
   parameter int BANK_DEPTH = 4225,
   parameter int BANK_AW    = 13
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [1:0]             wr_bank,
   input  logic [BANK_AW-1:0]     wr_addr,
   input  logic [ENTRY_W-1:0]     wr_data,
   input  logic                   rd_en,
   input  logic [3:0][BANK_AW-1:0] rd_addr,
   output logic [3:0][ENTRY_W-1:0] rd_data
);

   // Four banks selected by {row parity, column parity}, so the four corners
   // of any cell always fall into four different banks.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [ENTRY_W-1:0] mem [BANK_DEPTH];
      logic [ENTRY_W-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 2'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            q_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = q_ff;
   end

endmodule

/* hw/rtl/grid_warp_bilinear_remap.sv */
// Mesh-warp coordinate remapper.
// Input transactions arrive on req_payload and are taken at each rising edge
// where start is high and busy is low; busy is high only while reset is held.
// An opcode of write stores one grid node (u, v) and gives no result; an
// opcode of map remaps one screen point and gives exactly one result.
// Results appear on rsp_payload for one cycle, marked by rsp_valid, and the
// receiver has no way to hold them off.
// One transaction is accepted every cycle; the rate is set by the four grid
// banks, each read once and written at most once per cycle.
// Writes and reads reach the banks at the same pipeline stage in order, so a
// map that follows a write always sees the new node.
// Configuration (screen width, screen height, viewport size) is written over
// csr_we / csr_index / csr_wdata while the block is idle.
// Synchronous reset clears the pipeline and restores register defaults; the
// grid contents are undefined until written, so every node a map touches
// must have been written first. No clearing pass is done after reset.
module grid_warp_bilinear_remap
   import gwbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   output rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int DIM_W      = $clog2(MAX_SCREEN_DIM + 1);
   localparam int CW         = (DIM_W > CSR_W) ? DIM_W : CSR_W;
   localparam int GRID_DIM   = (MAX_SCREEN_DIM >> CELL_SHIFT) + 1;
   localparam int IDX_W      = $clog2(GRID_DIM);
   localparam int BANK_DIM   = (GRID_DIM + 1) / 2;
   localparam int BANK_W     = $clog2(BANK_DIM);
   localparam int BANK_DEPTH = BANK_DIM * BANK_DIM;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int FR_W       = CELL_SHIFT + 1;
   localparam int WT_W       = 2 * CELL_SHIFT + 1;
   localparam int BL_W       = NODE_W + 2 * CELL_SHIFT;
   localparam int SH         = FRACTION_BITS + 2 * CELL_SHIFT;
   localparam int PR_W       = BL_W + CSR_W + 1;
   localparam int RS_W       = PR_W - SH;
   localparam int SUM_W      = ((CW > RS_W) ? CW : RS_W) + 1;

   localparam logic [CW-1:0]   MIN_DIM   = CW'(1 << CELL_SHIFT);
   localparam logic [CW-1:0]   MAX_DIM   = CW'(MAX_SCREEN_DIM);
   localparam logic [FR_W-1:0] CELL_SIZE = FR_W'(1 << CELL_SHIFT);
   localparam logic [PR_W-1:0] HALF      = PR_W'(1) << (SH - 1);

   // ---------------------------------------------------------------------
   // Configuration registers and the values derived from them.
   // ---------------------------------------------------------------------
   logic [CSR_W-1:0] width_ff, height_ff, vport_ff;
   logic [CW-1:0]    w_in, h_in, vmin_in, vp_in, ww_in, hh_in, vv_in;
   logic [CW-1:0]    wm1_ff, hm1_ff, offx_ff, offy_ff;
   logic [IDX_W-1:0] cols_ff, rows_ff;
   logic [CSR_W-1:0] vp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
         vport_ff  <= RST_VIEWPORT_SIZE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            CSR_VIEWPORT_SIZE: vport_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ww_in   = CW'(width_ff);
      hh_in   = CW'(height_ff);
      vv_in   = CW'(vport_ff);
      w_in    = (ww_in < MIN_DIM) ? MIN_DIM : ((ww_in > MAX_DIM) ? MAX_DIM : ww_in);
      h_in    = (hh_in < MIN_DIM) ? MIN_DIM : ((hh_in > MAX_DIM) ? MAX_DIM : hh_in);
      vmin_in = (w_in < h_in) ? w_in : h_in;
      vp_in   = (vv_in == '0) ? CW'(1) : ((vv_in > vmin_in) ? vmin_in : vv_in);
   end

   // These are registered from the configuration registers and settle before any
   // transaction accepted after a register write reaches the stage that uses them.
   always_ff @(posedge clock) begin
      wm1_ff  <= w_in - CW'(1);
      hm1_ff  <= h_in - CW'(1);
      cols_ff <= IDX_W'(w_in >> CELL_SHIFT);
      rows_ff <= IDX_W'(h_in >> CELL_SHIFT);
      vp_ff   <= CSR_W'(vp_in);
      offx_ff <= (w_in - vp_in) >> 1;
      offy_ff <= (h_in - vp_in) >> 1;
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the transaction.
   // ---------------------------------------------------------------------
   logic    accept;
   logic    s1_valid_ff;
   req_type s1_req_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_req_ff <= req_payload;
   end

   // ---------------------------------------------------------------------
   // Stage 2: saturate the point to the screen and flip y.
   // ---------------------------------------------------------------------
   logic [CW-1:0] ptx_in, pty_in, px_in, py_in;
   logic          s2_valid_ff;
   req_type       s2_req_ff;
   logic [CW-1:0] s2_px_ff, s2_py_ff;

   always_comb begin
      ptx_in = CW'(s1_req_ff.point_x);
      pty_in = CW'(s1_req_ff.point_y);
      px_in  = (ptx_in > wm1_ff) ? wm1_ff : ptx_in;
      py_in  = hm1_ff - ((pty_in > hm1_ff) ? hm1_ff : pty_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_req_ff <= s1_req_ff;
      s2_px_ff  <= px_in;
      s2_py_ff  <= py_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: cell split, bank addresses, memory access and corner weights.
   // ---------------------------------------------------------------------
   logic [CW-1:0]    ci_in, cj_in;
   logic [IDX_W-1:0] i_in, j_in;
   logic [FR_W-1:0]  fx_in, fy_in;
   logic [BANK_W-1:0] ih_in, jh_in, bcol_in, brow_in, wcol_in, wrow_in;
   logic [3:0][BANK_AW-1:0] rd_addr;
   logic [3:0][ENTRY_W-1:0] rd_data;
   logic               wr_en, rd_en, in_grid;
   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;

   always_comb begin
      ci_in = s2_px_ff >> CELL_SHIFT;
      cj_in = s2_py_ff >> CELL_SHIFT;
      // A point beyond the last full cell lands on its far edge.
      if (ci_in >= CW'(cols_ff)) begin
         i_in  = cols_ff - IDX_W'(1);
         fx_in = CELL_SIZE;
      end else begin
         i_in  = IDX_W'(ci_in);
         fx_in = FR_W'(s2_px_ff[CELL_SHIFT-1:0]);
      end
      if (cj_in >= CW'(rows_ff)) begin
         j_in  = rows_ff - IDX_W'(1);
         fy_in = CELL_SIZE;
      end else begin
         j_in  = IDX_W'(cj_in);
         fy_in = FR_W'(s2_py_ff[CELL_SHIFT-1:0]);
      end
      ih_in = BANK_W'(i_in >> 1);
      jh_in = BANK_W'(j_in >> 1);
      // Bank {rp, cp}: the corner row is j when its parity is rp, else j + 1.
      for (int b = 0; b < 4; b++) begin
         brow_in = jh_in + BANK_W'(j_in[0] & ~b[1]);
         bcol_in = ih_in + BANK_W'(i_in[0] & ~b[0]);
         rd_addr[b] = BANK_AW'(brow_in) * BANK_AW'(BANK_DIM) + BANK_AW'(bcol_in);
      end
      in_grid = (int'(s2_req_ff.grid_col) < GRID_DIM) && (int'(s2_req_ff.grid_row) < GRID_DIM);
      wcol_in = BANK_W'(s2_req_ff.grid_col >> 1);
      wrow_in = BANK_W'(s2_req_ff.grid_row >> 1);
      wr_addr = BANK_AW'(wrow_in) * BANK_AW'(BANK_DIM) + BANK_AW'(wcol_in);
      wr_bank = {s2_req_ff.grid_row[0], s2_req_ff.grid_col[0]};
      wr_en   = s2_valid_ff && (s2_req_ff.opcode == OP_WRITE) && in_grid;
      rd_en   = s2_valid_ff && (s2_req_ff.opcode == OP_MAP);
   end

   gwbr_grid_mem #(
      .BANK_DEPTH (BANK_DEPTH),
      .BANK_AW    (BANK_AW)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_bank (wr_bank),
      .wr_addr (wr_addr),
      .wr_data ({s2_req_ff.node_v, s2_req_ff.node_u}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic                s3_valid_ff;
   logic                s3_i0_ff, s3_j0_ff;
   logic [3:0][WT_W-1:0] s3_wt_ff;
   logic [FR_W-1:0]     wx0_in, wy0_in;

   always_comb begin
      wx0_in = CELL_SIZE - fx_in;
      wy0_in = CELL_SIZE - fy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= rd_en;
      end
      s3_i0_ff    <= i_in[0];
      s3_j0_ff    <= j_in[0];
      s3_wt_ff[0] <= WT_W'(wx0_in) * WT_W'(wy0_in);
      s3_wt_ff[1] <= WT_W'(fx_in) * WT_W'(wy0_in);
      s3_wt_ff[2] <= WT_W'(wx0_in) * WT_W'(fy_in);
      s3_wt_ff[3] <= WT_W'(fx_in) * WT_W'(fy_in);
   end

   // ---------------------------------------------------------------------
   // Stage 4: route banks to corners and weight each node.
   // ---------------------------------------------------------------------
   logic [3:0][ENTRY_W-1:0] node_in;
   logic                    s4_valid_ff;
   logic [3:0][BL_W-1:0]    s4_pu_ff, s4_pv_ff;

   always_comb begin
      node_in[0] = rd_data[{s3_j0_ff,  s3_i0_ff}];
      node_in[1] = rd_data[{s3_j0_ff, ~s3_i0_ff}];
      node_in[2] = rd_data[{~s3_j0_ff,  s3_i0_ff}];
      node_in[3] = rd_data[{~s3_j0_ff, ~s3_i0_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      for (int k = 0; k < 4; k++) begin
         s4_pu_ff[k] <= BL_W'(BL_W'(node_in[k][NODE_W-1:0]) * BL_W'(s3_wt_ff[k]));
         s4_pv_ff[k] <= BL_W'(BL_W'(node_in[k][ENTRY_W-1:NODE_W]) * BL_W'(s3_wt_ff[k]));
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: sum the four weighted corners.
   // ---------------------------------------------------------------------
   logic            s5_valid_ff;
   logic [BL_W-1:0] s5_bu_ff, s5_bv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_bu_ff <= s4_pu_ff[0] + s4_pu_ff[1] + s4_pu_ff[2] + s4_pu_ff[3];
      s5_bv_ff <= s4_pv_ff[0] + s4_pv_ff[1] + s4_pv_ff[2] + s4_pv_ff[3];
   end

   // ---------------------------------------------------------------------
   // Stage 6: scale by the viewport and round half up.
   // ---------------------------------------------------------------------
   logic [PR_W-1:0] su_in, sv_in;
   logic            s6_valid_ff;
   logic [RS_W-1:0] s6_rx_ff, s6_ry_ff;

   always_comb begin
      su_in = PR_W'(s5_bu_ff) * PR_W'(vp_ff) + HALF;
      sv_in = PR_W'(s5_bv_ff) * PR_W'(vp_ff) + HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_rx_ff <= su_in[PR_W-1:SH];
      s6_ry_ff <= sv_in[PR_W-1:SH];
   end

   // ---------------------------------------------------------------------
   // Stage 7: center, flip y back, saturate to the screen.
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0] mx_in, myf_in, wlim_in, hlim_in;
   logic [CW-1:0]    xo_in, yo_in;
   logic             out_valid_ff;
   rsp_type          out_ff;

   always_comb begin
      wlim_in = SUM_W'(wm1_ff);
      hlim_in = SUM_W'(hm1_ff);
      mx_in   = SUM_W'(offx_ff) + SUM_W'(s6_rx_ff);
      myf_in  = SUM_W'(offy_ff) + SUM_W'(s6_ry_ff);
      xo_in   = (mx_in > wlim_in) ? wm1_ff : CW'(mx_in);
      yo_in   = (myf_in > hlim_in) ? CW'(0) : CW'(hlim_in - myf_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s6_valid_ff;
      end
      out_ff.mapped_x <= xo_in[OUT_W-1:0];
      out_ff.mapped_y <= yo_in[OUT_W-1:0];
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* hw/rtl/gwbr_checker.sv */
module gwbr_checker
   import gwbr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid
);

   logic map_taken, write_taken;

   assign map_taken   = start && !busy && (req_payload.opcode == OP_MAP);
   assign write_taken = start && !busy && (req_payload.opcode == OP_WRITE);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_result_has_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(map_taken, MAP_LATENCY))
      else $error("result without a matching map transaction");

   a_write_is_silent: assert property (@(posedge clock) disable iff (reset)
      write_taken |-> ##MAP_LATENCY !rsp_valid)
      else $error("write transaction produced a result");

endmodule

bind grid_warp_bilinear_remap gwbr_checker u_gwbr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid)
);

/* sim/remap_checker.sv */
module remap_checker
   import gwbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   errors,
   output int                   outstanding
);

   localparam int MAX_DIM  = 2048;
   localparam int CELL     = 4;
   localparam int GRID_DIM = (MAX_DIM >> CELL) + 1;
   localparam int SCALE_SH = FRACTION_BITS + 2 * CELL;

   logic [ENTRY_W-1:0] grid_nodes [GRID_DIM*GRID_DIM];
   logic [CSR_W-1:0]   width_reg, height_reg, viewport_reg;
   rsp_type            expected_points [$];

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Cell index and fraction; past the last full cell all weight goes to the far node.
   function automatic void cell_split(input int unsigned c, input int unsigned cells,
                                      output int unsigned idx, output int unsigned frac);
      if ((c >> CELL) >= cells) begin
         idx  = cells - 1;
         frac = 1 << CELL;
      end else begin
         idx  = c >> CELL;
         frac = c & ((1 << CELL) - 1);
      end
   endfunction

   function automatic rsp_type remap_point(req_type r);
      int unsigned       w, h, vp, px, py, ci, rj, fx, fy, base;
      int unsigned       addr [4];
      longint unsigned   wt [4];
      longint unsigned   bu, bv, rx, ry, mx, myf;
      logic [ENTRY_W-1:0] e;
      rsp_type           res;
      w  = clip(width_reg, 1 << CELL, MAX_DIM);
      h  = clip(height_reg, 1 << CELL, MAX_DIM);
      vp = clip(viewport_reg, 1, (w < h) ? w : h);
      px = (r.point_x > w - 1) ? w - 1 : r.point_x;
      py = (r.point_y > h - 1) ? h - 1 : r.point_y;
      py = h - 1 - py;
      cell_split(px, w >> CELL, ci, fx);
      cell_split(py, h >> CELL, rj, fy);
      base = rj * GRID_DIM + ci;
      addr = '{base, base + 1, base + GRID_DIM, base + GRID_DIM + 1};
      wt[0] = (16 - fx) * (16 - fy);
      wt[1] = fx * (16 - fy);
      wt[2] = (16 - fx) * fy;
      wt[3] = fx * fy;
      bu = 0;
      bv = 0;
      for (int k = 0; k < 4; k++) begin
         e  = grid_nodes[addr[k]];
         bu += longint'(e[NODE_W-1:0]) * wt[k];
         bv += longint'(e[ENTRY_W-1:NODE_W]) * wt[k];
      end
      rx  = (bu * vp + (64'd1 << (SCALE_SH - 1))) >> SCALE_SH;
      ry  = (bv * vp + (64'd1 << (SCALE_SH - 1))) >> SCALE_SH;
      mx  = ((w - vp) >> 1) + rx;
      myf = ((h - vp) >> 1) + ry;
      if (mx > w - 1) mx = w - 1;
      res.mapped_x = mx[OUT_W-1:0];
      res.mapped_y = (myf > h - 1) ? '0 : OUT_W'(h - 1 - myf);
      return res;
   endfunction

   initial begin
      errors      = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_reg    <= RST_SCREEN_WIDTH;
         height_reg   <= RST_SCREEN_HEIGHT;
         viewport_reg <= RST_VIEWPORT_SIZE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_reg    <= csr_wdata;
               CSR_SCREEN_HEIGHT: height_reg   <= csr_wdata;
               CSR_VIEWPORT_SIZE: viewport_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result x=%0d y=%0d", rsp_payload.mapped_x,
                           rsp_payload.mapped_y);
               errors++;
            end else begin
               want = expected_points.pop_front();
               if (want.mapped_x !== rsp_payload.mapped_x ||
                   want.mapped_y !== rsp_payload.mapped_y) begin
                  if (errors < 10)
                     $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                              want.mapped_x, want.mapped_y,
                              rsp_payload.mapped_x, rsp_payload.mapped_y);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            if (req_payload.opcode == OP_MAP)
               expected_points.push_back(remap_point(req_payload));
            else if (req_payload.grid_col < GRID_DIM && req_payload.grid_row < GRID_DIM)
               grid_nodes[req_payload.grid_row * GRID_DIM + req_payload.grid_col] =
                  {req_payload.node_v, req_payload.node_u};
         end
      end
      outstanding <= expected_points.size();
   end

endmodule

/* sim/testbench.sv */
// Testbench for the mesh-warp remapper. The top only generates transactions and
// gives the verdict; remap_checker watches both channels, predicts every map
// result from its own copy of the grid and registers, and counts mismatches.
module testbench;
   import gwbr_pkg::*;

   localparam int GRID_DIM  = 129;
   localparam int TARGET    = 1050;
   localparam int MAX_CYCLE = 600000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_payload;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   errors;
   int                   outstanding;

   // The stimulus keeps its own register copy to know which nodes a map touches.
   int unsigned cfg_width, cfg_height, cfg_viewport;
   bit          node_written [GRID_DIM*GRID_DIM];
   bit          gaps_on;
   int          map_count, write_count, setting_count, cycle_count, sent_count;

   grid_warp_bilinear_remap dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   remap_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung block ends the run as a failure.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Drives one transaction after a random gap and holds it until the block takes it.
   // Busy is read at the falling edge, where it already shows the coming edge's value.
   task automatic issue(req_type r);
      int  gap;
      bit  taken;
      gap = gaps_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       = 1'b1;
      req_payload = r;
      taken       = 1'b0;
      while (!taken) begin
         taken = !busy;
         @(posedge clock);
         if (!taken) @(negedge clock);
      end
      sent_count++;
   endtask

   function automatic logic [NODE_W-1:0] node_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return NODE_W'(65536);
      if (pick == 2) return NODE_W'(65535);
      return NODE_W'($urandom_range(0, 65536));
   endfunction

   task automatic write_node(int col, int row, logic [NODE_W-1:0] u, logic [NODE_W-1:0] v);
      req_type r;
      r          = '0;
      r.opcode   = OP_WRITE;
      r.grid_col = col[GIDX_W-1:0];
      r.grid_row = row[GIDX_W-1:0];
      r.node_u   = u;
      r.node_v   = v;
      r.point_x  = PT_W'($urandom);
      r.point_y  = PT_W'($urandom);
      if (col < GRID_DIM && row < GRID_DIM) node_written[row * GRID_DIM + col] = 1'b1;
      issue(r);
   endtask

   // Locates the cell a point falls into, the same way the block does, so that its
   // four corner nodes can be written before the map is sent.
   function automatic int cell_of(int c, int lim, int cells);
      int s;
      s = (c > lim - 1) ? lim - 1 : c;
      return ((s >> 4) >= cells) ? cells - 1 : (s >> 4);
   endfunction

   task automatic map_point(int x, int y);
      int      w, h, ci, rj, py;
      req_type r;
      w  = (cfg_width < 16) ? 16 : (cfg_width > 2048) ? 2048 : cfg_width;
      h  = (cfg_height < 16) ? 16 : (cfg_height > 2048) ? 2048 : cfg_height;
      py = (y > h - 1) ? h - 1 : y;
      ci = cell_of(x, w, w >> 4);
      rj = cell_of(h - 1 - py, h, h >> 4);
      for (int dj = 0; dj < 2; dj++)
         for (int di = 0; di < 2; di++)
            if (!node_written[(rj + dj) * GRID_DIM + ci + di])
               write_node(ci + di, rj + dj, node_value(), node_value());
      r          = '0;
      r.opcode   = OP_MAP;
      r.grid_col = GIDX_W'($urandom);
      r.grid_row = GIDX_W'($urandom);
      r.node_u   = NODE_W'($urandom);
      r.node_v   = NODE_W'($urandom);
      r.point_x  = x[PT_W-1:0];
      r.point_y  = y[PT_W-1:0];
      map_count++;
      issue(r);
   endtask

   // Registers change only with the pipeline drained and then a further wait,
   // since a node write gives no result to wait for.
   task automatic set_screen(int unsigned w, int unsigned h, int unsigned vp);
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (MAP_LATENCY + 3) @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_SCREEN_WIDTH;
      csr_wdata = w[CSR_W-1:0];
      @(negedge clock);
      csr_index = CSR_SCREEN_HEIGHT;
      csr_wdata = h[CSR_W-1:0];
      @(negedge clock);
      csr_index = CSR_VIEWPORT_SIZE;
      csr_wdata = vp[CSR_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      cfg_width    = w[CSR_W-1:0];
      cfg_height   = h[CSR_W-1:0];
      cfg_viewport = vp[CSR_W-1:0];
      setting_count++;
   endtask

   // Points are mostly on screen, with a share near the edges and a share off it.
   task automatic random_map();
      int pick, x, y;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         x = $urandom_range(0, 2047);
         y = $urandom_range(0, 2047);
      end else if (pick < 4) begin
         x = (cfg_width  > 2048 || cfg_width  < 16) ? 2047 : cfg_width  - $urandom_range(1, 20);
         y = (cfg_height > 2048 || cfg_height < 16) ? 2047 : cfg_height - $urandom_range(1, 20);
         if (x < 0) x = 0;
         if (y < 0) y = 0;
         if ($urandom_range(0, 1)) x = $urandom_range(0, 17);
      end else begin
         x = $urandom_range(0, (cfg_width  >= 16 && cfg_width  <= 2048) ? cfg_width  - 1 : 2047);
         y = $urandom_range(0, (cfg_height >= 16 && cfg_height <= 2048) ? cfg_height - 1 : 2047);
      end
      map_point(x, y);
   endtask

   initial begin
      int budget, pick;
      reset         = 1'b1;
      start         = 1'b0;
      req_payload   = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_SCREEN_WIDTH;
      csr_wdata     = '0;
      gaps_on       = 1'b1;
      map_count     = 0;
      write_count   = 0;
      sent_count    = 0;
      setting_count = 1;
      cfg_width     = RST_SCREEN_WIDTH;
      cfg_height    = RST_SCREEN_HEIGHT;
      cfg_viewport  = RST_VIEWPORT_SIZE;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part: node extremes, writes outside the grid, the screen
      // corners, points off screen and the clamp past the last full cell.
      write_node(0, 0, '0, NODE_W'(65536));
      write_node(128, 128, NODE_W'(65536), NODE_W'(65535));
      write_node(255, 3, NODE_W'(65536), NODE_W'(65536));
      write_node(3, 129, NODE_W'(65536), NODE_W'(65536));
      map_point(0, 0);
      map_point(1023, 767);
      map_point(2047, 2047);
      map_point(512, 384);
      set_screen(2048, 2048, 2048);
      map_point(2047, 0);
      map_point(0, 2047);
      map_point(1031, 1031);
      set_screen(16, 16, 16);
      map_point(0, 0);
      map_point(15, 15);
      map_point(2047, 9);
      set_screen(1000, 600, 600);
      map_point(999, 0);
      map_point(995, 599);
      // Out-of-range register values get clamped by the block.
      set_screen(4095, 0, 0);
      map_point(2047, 2047);
      map_point(100, 3);
      set_screen(40, 2047, 4095);
      map_point(39, 2046);
      map_point(20, 0);

      // Random part: several register settings, each with a burst of traffic.
      // Every transaction sent, corner writes included, counts toward the target.
      while (sent_count < TARGET) begin
         pick = $urandom_range(0, 3);
         if (pick == 0)
            set_screen($urandom_range(16, 2048), $urandom_range(16, 2048),
                       $urandom_range(1, 2048));
         else if (pick == 1)
            set_screen($urandom_range(16, 160), $urandom_range(16, 160),
                       $urandom_range(1, 160));
         else if (pick == 2)
            set_screen($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
         else
            set_screen(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_VIEWPORT_SIZE);
         budget = $urandom_range(60, 140);
         for (int n = 0; n < budget && sent_count < TARGET; n++) begin
            if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               random_map();
            end else if (pick < 19) begin
               write_node($urandom_range(0, GRID_DIM - 1), $urandom_range(0, GRID_DIM - 1),
                          node_value(), node_value());
               write_count++;
            end else if ($urandom_range(0, 1)) begin
               write_node($urandom_range(GRID_DIM, 255), $urandom_range(0, 255),
                          node_value(), node_value());
            end else begin
               write_node($urandom_range(0, 255), $urandom_range(GRID_DIM, 255),
                          node_value(), node_value());
            end
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (MAP_LATENCY + 5) @(negedge clock);

      $display("Sent %0d transactions: %0d maps and %0d random node writes.",
               sent_count, map_count, write_count);
      $display("Used %0d screen settings, extremes and out-of-range values included.",
               setting_count);
      if (errors == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/gwbr_pkg.sv
hw/rtl/gwbr_grid_mem.sv
hw/rtl/grid_warp_bilinear_remap.sv
hw/rtl/gwbr_checker.sv
sim/remap_checker.sv
sim/testbench.sv
